### rtl/lfia_pkg.sv
// Shared widths, request and status codes, and register map of the lowest-free id allocator.
`timescale 1ns / 1ps

package lfia_pkg;

    localparam int ID_W       = 13;
    localparam int REQ_W      = 2;
    localparam int ST_W       = 3;
    localparam int DATA_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

    localparam logic [ST_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [ST_W-1:0] ST_NONE_FREE = 3'd1;
    localparam logic [ST_W-1:0] ST_RELEASED  = 3'd2;
    localparam logic [ST_W-1:0] ST_REJECTED  = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd4;

    // register select is paddr[2]
    localparam logic CFG_LOWEST  = 1'b0;
    localparam logic CFG_HIGHEST = 1'b1;

    localparam logic [ID_W-1:0] LOWEST_RST  = 13'd300;
    localparam logic [ID_W-1:0] HIGHEST_RST = 13'd5000;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ST_W-1:0] status;
    } res_t;

endpackage

### rtl/lowest_free_id_allocator_top.sv
// Lowest-free id allocator: bitmap in one synchronous RAM, word scan, read-modify-write.
//
//  channel   direction  handshake                  payload
//  s_        in         s_tvalid / s_tready        s_tdata: release_id; s_tuser: req_type
//  m_        out        m_tvalid / m_tready        m_tdata: granted_id; m_tuser: status
//  apb       in         psel, penable, pready=1    lowest_id @0x0, highest_id @0x4
//
// Allocate reads one map word per cycle over the single RAM read port, from word 0
// through the word holding the upper bound.
// Release does a reciprocal multiply, a word read and a write back; clear writes one
// RAM word per cycle.
// After reset the RAM is swept to zero, all MAP_WORDS words (128 by default), with
// s_tready low. A result waits in an output register, so the next request is taken
// while m_tready is low; a finished request holds until that register is free.
`timescale 1ns / 1ps

module lowest_free_id_allocator_top #(
    parameter int NUM_IDS   = 8192,
    parameter int WORD_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lfia_pkg::DATA_W-1:0]        s_tdata,   // [12:0] release_id, [15:13] zero
    input  logic [lfia_pkg::REQ_W-1:0]         s_tuser,   // [1:0] req_type

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lfia_pkg::DATA_W-1:0]        m_tdata,   // [12:0] granted_id, [15:13] zero
    output logic [lfia_pkg::ST_W-1:0]          m_tuser,   // [2:0] status

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lfia_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lfia_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lfia_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int ID_W      = lfia_pkg::ID_W;
    localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAP_WORDS + 1);
    localparam int BW        = $clog2(NUM_IDS + WORD_BITS);
    localparam int CMP_W     = ((BW > ID_W) ? BW : ID_W) + 1;
    localparam int LOG_W     = $clog2(WORD_BITS);
    localparam int PAD_W     = 1 << LOG_W;
    localparam int DIV_SH    = ID_W + LOG_W;
    localparam int RECIP_W   = DIV_SH - LOG_W + 2;
    localparam int PROD_W    = ID_W + RECIP_W;
    localparam int Q_W       = PROD_W - DIV_SH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FOUND = 3'd3;
    localparam logic [2:0] S_RDIV  = 3'd4;
    localparam logic [2:0] S_RADDR = 3'd5;
    localparam logic [2:0] S_RMW   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // lowest set bit, halving the window each step
    function automatic logic [LOG_W-1:0] first_set(input logic [WORD_BITS-1:0] vec);
        logic [PAD_W-1:0] v;
        logic [LOG_W-1:0] idx;
        v   = PAD_W'(vec);
        idx = '0;
        for (int l = LOG_W - 1; l >= 0; l--) begin
            if ((v & ((PAD_W'(1) << (1 << l)) - PAD_W'(1))) == '0) begin
                idx[l] = 1'b1;
                v      = v >> (1 << l);
            end
        end
        return idx;
    endfunction

    logic [2:0]              state_reg, state_next;
    logic                    clr_req_reg, clr_req_next;
    logic [ID_W-1:0]         lo_reg, hi_reg;
    logic [CNT_W-1:0]        iss_cnt_reg, iss_cnt_next;
    logic [BW-1:0]           iss_base_reg, iss_base_next;
    logic                    dv_reg, dv_next;
    logic [ADDR_W-1:0]       dat_addr_reg, dat_addr_next;
    logic [BW-1:0]           dat_base_reg, dat_base_next;
    logic [WORD_BITS-1:0]    mask_reg, mask_next;
    logic [WORD_BITS-1:0]    fnd_vec_reg, fnd_vec_next;
    logic [WORD_BITS-1:0]    fnd_word_reg, fnd_word_next;
    logic [ADDR_W-1:0]       fnd_addr_reg, fnd_addr_next;
    logic [BW-1:0]           fnd_base_reg, fnd_base_next;
    logic [ID_W-1:0]         rel_reg, rel_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [LOG_W-1:0]        bpos_reg, bpos_next;
    logic [ADDR_W-1:0]       raddr_reg, raddr_next;
    lfia_pkg::res_t          res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    lfia_pkg::res_t          out_res_reg, out_res_next;

    logic [WORD_BITS-1:0]    mem [0:MAP_WORDS-1];
    logic [WORD_BITS-1:0]    rd_data_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [WORD_BITS-1:0]    mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;

    logic [CMP_W-1:0]        lo_ext, hi_eff;
    logic [CMP_W-1:0]        rel_ext;
    logic                    s_acc;
    logic                    cfg_wr;
    logic                    can_issue;
    logic [WORD_BITS-1:0]    range_mask;
    logic [WORD_BITS-1:0]    free_vec;
    logic [LOG_W-1:0]        bidx;
    logic [Q_W-1:0]          quot;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == lfia_pkg::CFG_HIGHEST) ? lfia_pkg::CFG_DATA_W'(hi_reg)
                                                        : lfia_pkg::CFG_DATA_W'(lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= lfia_pkg::LOWEST_RST;
            hi_reg <= lfia_pkg::HIGHEST_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == lfia_pkg::CFG_LOWEST) begin
                lo_reg <= pwdata[ID_W-1:0];
            end else begin
                hi_reg <= pwdata[ID_W-1:0];
            end
        end
    end

    // upper bound clipped to the map
    assign lo_ext  = CMP_W'(lo_reg);
    assign hi_eff  = (CMP_W'(hi_reg) > CMP_W'(NUM_IDS - 1)) ? CMP_W'(NUM_IDS - 1)
                                                            : CMP_W'(hi_reg);
    assign rel_ext = CMP_W'(s_tdata[ID_W-1:0]);

    // ---------------- map RAM ----------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // ---------------- datapath helpers ----------------
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign can_issue = (iss_cnt_reg < CNT_W'(MAP_WORDS)) && (CMP_W'(iss_base_reg) <= hi_eff);
    assign free_vec  = ~rd_data_reg & mask_reg;
    assign bidx      = first_set(fnd_vec_reg);
    assign quot      = prod_reg[PROD_W-1:DIV_SH];

    always_comb begin
        logic [CMP_W-1:0] id_b;
        range_mask = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            id_b          = CMP_W'(iss_base_reg) + CMP_W'(b);
            range_mask[b] = (id_b >= lo_ext) && (id_b <= hi_eff);
        end
    end

    // ---------------- control ----------------
    always_comb begin
        state_next     = state_reg;
        clr_req_next   = clr_req_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_base_next  = iss_base_reg;
        dv_next        = dv_reg;
        dat_addr_next  = dat_addr_reg;
        dat_base_next  = dat_base_reg;
        mask_next      = mask_reg;
        fnd_vec_next   = fnd_vec_reg;
        fnd_word_next  = fnd_word_reg;
        fnd_addr_next  = fnd_addr_reg;
        fnd_base_next  = fnd_base_reg;
        rel_next       = rel_reg;
        prod_next      = prod_reg;
        bpos_next      = bpos_reg;
        raddr_next     = raddr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_res_next   = out_res_reg;
        mem_we         = 1'b0;
        mem_waddr      = iss_cnt_reg[ADDR_W-1:0];
        mem_wdata      = '0;
        mem_raddr      = iss_cnt_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (iss_cnt_reg == CNT_W'(MAP_WORDS - 1)) begin
                    if (clr_req_reg) begin
                        res_next.id     = '0;
                        res_next.status = lfia_pkg::ST_CLEARED;
                        clr_req_next    = 1'b0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    res_next.id = '0;
                    unique case (s_tuser)
                        lfia_pkg::REQ_ALLOC: begin
                            if (lo_ext > hi_eff) begin
                                res_next.status = lfia_pkg::ST_NONE_FREE;
                                state_next      = S_DONE;
                            end else begin
                                iss_cnt_next  = '0;
                                iss_base_next = '0;
                                dv_next       = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        lfia_pkg::REQ_RELEASE: begin
                            if ((rel_ext >= lo_ext) && (rel_ext <= hi_eff)) begin
                                rel_next   = s_tdata[ID_W-1:0];
                                state_next = S_RDIV;
                            end else begin
                                res_next.status = lfia_pkg::ST_REJECTED;
                                state_next      = S_DONE;
                            end
                        end
                        lfia_pkg::REQ_CLEAR: begin
                            iss_cnt_next = '0;
                            clr_req_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default: begin
                            res_next.status = lfia_pkg::ST_REJECTED;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one word per cycle; judge the word read the cycle before
                dv_next = can_issue;
                if (can_issue) begin
                    dat_addr_next = iss_cnt_reg[ADDR_W-1:0];
                    dat_base_next = iss_base_reg;
                    mask_next     = range_mask;
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                    iss_base_next = iss_base_reg + BW'(WORD_BITS);
                end
                if (dv_reg && (free_vec != '0)) begin
                    fnd_vec_next  = free_vec;
                    fnd_word_next = rd_data_reg;
                    fnd_addr_next = dat_addr_reg;
                    fnd_base_next = dat_base_reg;
                    dv_next       = 1'b0;
                    state_next    = S_FOUND;
                end else if (!dv_reg && !can_issue) begin
                    res_next.id     = '0;
                    res_next.status = lfia_pkg::ST_NONE_FREE;
                    state_next      = S_DONE;
                end
            end
            S_FOUND: begin
                mem_we          = 1'b1;
                mem_waddr       = fnd_addr_reg;
                mem_wdata       = fnd_word_reg | (WORD_BITS'(1) << bidx);
                res_next.id     = ID_W'(CMP_W'(fnd_base_reg) + CMP_W'(bidx));
                res_next.status = lfia_pkg::ST_ALLOCATED;
                state_next      = S_DONE;
            end
            S_RDIV: begin
                prod_next  = PROD_W'(rel_reg) * PROD_W'(RECIP);
                state_next = S_RADDR;
            end
            S_RADDR: begin
                mem_raddr  = ADDR_W'(quot);
                raddr_next = ADDR_W'(quot);
                bpos_next  = LOG_W'(rel_reg - ID_W'(ID_W'(quot) * ID_W'(WORD_BITS)));
                state_next = S_RMW;
            end
            S_RMW: begin
                mem_we          = 1'b1;
                mem_waddr       = raddr_reg;
                mem_wdata       = rd_data_reg & ~(WORD_BITS'(1) << bpos_reg);
                res_next.id     = '0;
                res_next.status = lfia_pkg::ST_RELEASED;
                state_next      = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_req_reg   <= 1'b0;
            iss_cnt_reg   <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_req_reg   <= clr_req_next;
            iss_cnt_reg   <= iss_cnt_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_base_reg <= iss_base_next;
        dat_addr_reg <= dat_addr_next;
        dat_base_reg <= dat_base_next;
        mask_reg     <= mask_next;
        fnd_vec_reg  <= fnd_vec_next;
        fnd_word_reg <= fnd_word_next;
        fnd_addr_reg <= fnd_addr_next;
        fnd_base_reg <= fnd_base_next;
        rel_reg      <= rel_next;
        prod_reg     <= prod_next;
        bpos_reg     <= bpos_next;
        raddr_reg    <= raddr_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lfia_pkg::DATA_W'(out_res_reg.id);
    assign m_tuser  = out_res_reg.status;

`ifndef SYNTHESIS
    a_grant_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == lfia_pkg::ST_ALLOCATED)) |->
            ((CMP_W'(m_tdata[ID_W-1:0]) >= lo_ext) && (CMP_W'(m_tdata[ID_W-1:0]) <= hi_eff)))
        else $error("granted id outside configured range");

    a_zero_id_otherwise: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != lfia_pkg::ST_ALLOCATED)) |-> (m_tdata == '0))
        else $error("non-allocate result carries an id");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == S_CLEAR) || (state_reg == S_FOUND) || (state_reg == S_RMW)))
        else $error("map write outside a write state");

    a_found_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FOUND) |=> (state_reg == S_DONE))
        else $error("allocation did not finish after the write back");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == lfia_pkg::REQ_CLEAR)) |=> ((state_reg == S_CLEAR) && !s_tready))
        else $error("clear request did not start the sweep");
`endif

endmodule
